[src/msbw_pkg.sv]
`timescale 1ns / 1ps

package msbw_pkg;

   // Limits on one request
   localparam int MaxFieldBits  = 32;
   localparam int MaxWriteBytes = 8;
   localparam int ByteBits      = 8;

   // Request codes
   localparam logic [1:0] REQ_BITS  = 2'd0;
   localparam logic [1:0] REQ_BYTES = 2'd1;
   localparam logic [1:0] REQ_FLUSH = 2'd2;

   // Bit-field packing window: one byte of partial bits on top of the field
   localparam int AccBytes  = (MaxFieldBits + ByteBits - 1) / ByteBits + 1;
   localparam int AccW      = AccBytes * ByteBits;
   localparam int AccIdxW   = $clog2(AccBytes);
   localparam int ShiftW    = $clog2(AccW + 1);

   // One job: every byte a request produces, in stream order
   localparam int MaxJobBytes = (AccBytes > MaxWriteBytes + 1) ? AccBytes
                                                               : MaxWriteBytes + 1;
   localparam int JobCntW     = $clog2(MaxJobBytes + 1);
   localparam int JobIdxW     = $clog2(MaxJobBytes);
   localparam int FieldCntW   = 6;
   localparam int ByteCntW    = $clog2(MaxWriteBytes + 1);

   localparam int QueueDepth  = 2;
   localparam int QueuePtrW   = $clog2(QueueDepth);
   localparam int QueueCntW   = $clog2(QueueDepth + 1);

   typedef struct packed {
      logic [MaxJobBytes-1:0][ByteBits-1:0] bytes;
      logic [JobCntW-1:0]                   count;
   } job_type;

endpackage

[src/msb_first_bit_stream_writer_core.sv]
`timescale 1ns / 1ps

// MSB-first bit stream writer. Each request transfer either appends a bit field of
// 1 to 32 bits (most significant bit first), writes 1 to 8 whole bytes after padding
// any partial byte with zeros (most significant byte first or lowest byte first),
// or flushes the partial byte (pad and emit, or keep it). Every completed byte
// comes out as one response transfer, in stream order, and the final byte caused
// by a request carries rsp_last_of_run. Requests that complete no byte produce no
// response. The front end takes one request per cycle while the job queue is not
// full, packs it into a job of up to nine bytes and updates the partial-byte state
// in the same cycle; a two-entry job queue separates it from the back end, which
// drains one byte per cycle, unless the response side stalls, into the response
// register. That byte drain sets the pace; requests that produce no byte never
// enter the queue. On its way to the first byte a request passes the queue entry,
// the back end's job register and the response register.
module msb_first_bit_stream_writer_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [1:0]                      req_type,
   input  logic [63:0]                     req_data_value,
   input  logic [msbw_pkg::FieldCntW-1:0]  req_field_count,
   input  logic                            req_msb_byte_first,
   input  logic                            req_pad_partial,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [7:0]                      rsp_out_byte,
   output logic                            rsp_last_of_run
);
   import msbw_pkg::*;

   logic    job_valid;
   job_type job;
   logic    job_full;
   logic    head_valid;
   job_type head_job;
   logic    pop;

   // Classify, pack and advance the partial-byte state
   msbw_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_type           (req_type),
      .req_data_value     (req_data_value),
      .req_field_count    (req_field_count),
      .req_msb_byte_first (req_msb_byte_first),
      .req_pad_partial    (req_pad_partial),
      .job_valid          (job_valid),
      .job                (job),
      .job_full           (job_full)
   );

   // Hold jobs so either side can stall on its own
   msbw_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (job_valid),
      .push_job   (job),
      .full       (job_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   // Drain one byte per cycle, unless the response side stalls, into the response register
   msbw_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head_valid      (head_valid),
      .head_job        (head_job),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule

[src/msbw_front.sv]
`timescale 1ns / 1ps

module msbw_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [1:0]                   req_type,
   input  logic [63:0]                  req_data_value,
   input  logic [msbw_pkg::FieldCntW-1:0] req_field_count,
   input  logic                         req_msb_byte_first,
   input  logic                         req_pad_partial,
   output logic                         job_valid,
   output msbw_pkg::job_type            job,
   input  logic                         job_full
);
   import msbw_pkg::*;

   logic [ByteBits-1:0] partial_ff, partial_in;
   logic [2:0]          fill_ff, fill_in;

   logic                          accept;
   logic [FieldCntW-1:0]          fcnt;
   logic [MaxFieldBits-1:0]       fmask;
   logic [MaxFieldBits-1:0]       field;
   logic [ShiftW-1:0]             sh;
   logic [AccBytes-1:0][ByteBits-1:0] acc;
   logic [ShiftW-1:0]             total;
   logic [JobCntW-1:0]            nbytes;
   logic [AccIdxW-1:0]            rem_idx;
   logic [ByteCntW-1:0]           bcnt;
   logic [7:0][ByteBits-1:0]      dbytes;
   logic                          has_partial;
   logic [JobCntW-1:0]            k;
   logic [JobCntW-1:0]            sel;

   assign accept      = req_valid && !job_full;
   assign req_stall   = job_full;
   assign has_partial = (fill_ff != 3'd0);
   assign dbytes      = req_data_value;

   // Bit-field path: line the field up right behind the partial bits
   always_comb begin
      fcnt  = (req_field_count > FieldCntW'(MaxFieldBits)) ? FieldCntW'(MaxFieldBits)
                                                           : req_field_count;
      fmask = ~({MaxFieldBits{1'b1}} << fcnt);
      field = req_data_value[MaxFieldBits-1:0] & fmask;
      sh    = ShiftW'(AccW) - ShiftW'(fill_ff) - ShiftW'(fcnt);
      acc   = {partial_ff, {(AccW-ByteBits){1'b0}}}
            | ({{(AccW-MaxFieldBits){1'b0}}, field} << sh);
      total = ShiftW'(fill_ff) + ShiftW'(fcnt);
      nbytes  = JobCntW'(total >> 3);
      rem_idx = AccIdxW'(AccBytes - 1) - AccIdxW'(nbytes);
      bcnt = (req_field_count > FieldCntW'(MaxWriteBytes)) ? ByteCntW'(MaxWriteBytes)
                                                           : ByteCntW'(req_field_count);
   end

   always_comb begin
      job        = '0;
      partial_in = partial_ff;
      fill_in    = fill_ff;
      k          = '0;
      sel        = '0;
      unique case (req_type)
         REQ_BITS: begin
            for (int j = 0; j < AccBytes; j++) begin
               job.bytes[j] = acc[AccBytes-1-j];
            end
            job.count  = nbytes;
            partial_in = acc[rem_idx];
            fill_in    = total[2:0];
         end
         REQ_BYTES: begin
            for (int j = 0; j < MaxJobBytes; j++) begin
               k   = JobCntW'(j) - JobCntW'(has_partial);
               sel = req_msb_byte_first ? (JobCntW'(bcnt) - JobCntW'(1) - k) : k;
               job.bytes[j] = (has_partial && j == 0) ? partial_ff : dbytes[sel[2:0]];
            end
            job.count  = JobCntW'(bcnt) + JobCntW'(has_partial);
            partial_in = '0;
            fill_in    = '0;
         end
         REQ_FLUSH: begin
            job.bytes[0] = partial_ff;
            if (req_pad_partial && has_partial) begin
               job.count  = JobCntW'(1);
               partial_in = '0;
               fill_in    = '0;
            end
         end
         default: begin
            job = '0;
         end
      endcase
   end

   // Drop requests that produce no byte
   assign job_valid = accept && (job.count != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         partial_ff <= '0;
         fill_ff    <= '0;
      end else if (accept) begin
         partial_ff <= partial_in;
         fill_ff    <= fill_in;
      end
   end

endmodule

[src/msbw_queue.sv]
`timescale 1ns / 1ps

module msbw_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  msbw_pkg::job_type push_job,
   output logic              full,
   input  logic              pop,
   output logic              head_valid,
   output msbw_pkg::job_type head_job
);
   import msbw_pkg::*;

   job_type              entry_ff [QueueDepth];
   logic [QueuePtrW-1:0] wr_ff, wr_in;
   logic [QueuePtrW-1:0] rd_ff, rd_in;
   logic [QueueCntW-1:0] cnt_ff, cnt_in;
   logic                 do_push;
   logic                 do_pop;

   assign full       = (cnt_ff == QueueCntW'(QueueDepth));
   assign head_valid = (cnt_ff != '0);
   assign head_job   = entry_ff[rd_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_in  = do_push ? QueuePtrW'(wr_ff + 1'b1) : wr_ff;
      rd_in  = do_pop  ? QueuePtrW'(rd_ff + 1'b1) : rd_ff;
      cnt_in = cnt_ff + QueueCntW'(do_push) - QueueCntW'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ff] <= push_job;
      end
   end

endmodule

[src/msbw_back.sv]
`timescale 1ns / 1ps

module msbw_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              head_valid,
   input  msbw_pkg::job_type head_job,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [7:0]        rsp_out_byte,
   output logic              rsp_last_of_run
);
   import msbw_pkg::*;

   job_type            job_ff;
   logic               busy_ff, busy_in;
   logic [JobIdxW-1:0] idx_ff, idx_in;
   logic               valid_ff, valid_in;
   logic [7:0]         byte_ff;
   logic               last_ff;
   logic               out_load;
   logic               fire;
   logic               at_last;

   assign out_load = !valid_ff || !rsp_stall;
   assign fire     = busy_ff && out_load;
   assign at_last  = (JobCntW'(idx_ff) == job_ff.count - JobCntW'(1));
   assign pop      = head_valid && (!busy_ff || (fire && at_last));

   always_comb begin
      busy_in  = busy_ff;
      idx_in   = idx_ff;
      valid_in = valid_ff;
      if (out_load) begin
         valid_in = fire;
      end
      if (fire) begin
         idx_in = JobIdxW'(idx_ff + 1'b1);
         if (at_last) begin
            busy_in = 1'b0;
         end
      end
      if (pop) begin
         busy_in = 1'b1;
         idx_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         job_ff <= head_job;
      end
      if (fire) begin
         byte_ff <= job_ff.bytes[idx_ff];
         last_ff <= at_last;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_out_byte    = byte_ff;
   assign rsp_last_of_run = last_ff;

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps

// Self-checking bench for the MSB-first bit stream writer: stimulus tasks push
// request transfers through one shared sender, a built-in packer model predicts the
// byte stream, and a monitor compares each response transfer with the oldest
// predicted byte.
module testbench;
   import msbw_pkg::*;

   // Code the block must ignore
   localparam logic [1:0] REQ_UNUSED = 2'd3;

   localparam int QuietLimit = 1000;   // cycles with no transfer on either side
   localparam int TailCycles = 20;     // settle time after the last byte arrives

   typedef struct packed {
      logic [7:0] value;
      logic       last;
   } stream_byte_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_type = REQ_FLUSH;
   logic [63:0] req_data_value = '0;
   logic [FieldCntW-1:0] req_field_count = '0;
   logic        req_msb_byte_first = 1'b0;
   logic        req_pad_partial = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_out_byte;
   logic        rsp_last_of_run;

   // Packer model state and the bytes it still owes the monitor
   logic [7:0]      model_partial;
   int              model_fill;
   stream_byte_type owed_bytes[$];

   bit idling_on;
   int rsp_stall_left;
   int quiet_cycles;
   int error_count;
   int requests_sent;
   int bytes_checked;
   int last_marks_seen;

   msb_first_bit_stream_writer_core dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_type           (req_type),
      .req_data_value     (req_data_value),
      .req_field_count    (req_field_count),
      .req_msb_byte_first (req_msb_byte_first),
      .req_pad_partial    (req_pad_partial),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_out_byte       (rsp_out_byte),
      .rsp_last_of_run    (rsp_last_of_run)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Pad the unfinished byte with zeros and hand it out, if any bits are held.
   task automatic pad_partial_byte(inout stream_byte_type produced[$]);
      if (model_fill != 0) begin
         produced.push_back('{value: model_partial, last: 1'b0});
         model_partial = '0;
         model_fill = 0;
      end
   endtask

   // Advance the packer model by one request and queue the bytes it completes.
   task automatic predict_packed_bytes(input logic [1:0] kind, input logic [63:0] data,
                                       input logic [FieldCntW-1:0] count,
                                       input logic msb_first, input logic pad);
      stream_byte_type produced[$];
      int n;
      int idx;
      n = int'(count);
      case (kind)
         REQ_BITS: begin
            if (n > MaxFieldBits) n = MaxFieldBits;
            for (int i = n - 1; i >= 0; i--) begin
               model_partial[7 - model_fill] = data[i];
               model_fill++;
               if (model_fill == ByteBits) begin
                  produced.push_back('{value: model_partial, last: 1'b0});
                  model_partial = '0;
                  model_fill = 0;
               end
            end
         end
         REQ_BYTES: begin
            pad_partial_byte(produced);
            if (n > MaxWriteBytes) n = MaxWriteBytes;
            for (int k = 0; k < n; k++) begin
               idx = msb_first ? (n - 1 - k) : k;
               produced.push_back('{value: data[idx*8 +: 8], last: 1'b0});
            end
         end
         REQ_FLUSH: begin
            if (pad) pad_partial_byte(produced);
         end
         default: ;   // unused code: no effect
      endcase
      if (produced.size() > 0) produced[produced.size() - 1].last = 1'b1;
      foreach (produced[i]) owed_bytes.push_back(produced[i]);
   endtask

   // Present one request, hold it until the block takes it, then predict.
   task automatic send_request(input logic [1:0] kind, input logic [63:0] data,
                               input logic [FieldCntW-1:0] count,
                               input logic msb_first, input logic pad);
      if (idling_on && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_type           <= kind;
      req_data_value     <= data;
      req_field_count    <= count;
      req_msb_byte_first <= msb_first;
      req_pad_partial    <= pad;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_packed_bytes(kind, data, count, msb_first, pad);
      requests_sent++;
   endtask

   function automatic logic [63:0] random_data();
      return {$urandom(), $urandom()};
   endfunction

   // Response side: stall in random bursts while idling is on.
   always @(posedge clock) begin
      if (idling_on && rsp_stall_left > 0) begin
         rsp_stall_left--;
         rsp_stall <= 1'b1;
      end else if (idling_on && !reset && $urandom_range(0, 5) == 0) begin
         rsp_stall_left = $urandom_range(1, 11) - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Compare every response transfer with the oldest owed byte.
   always @(posedge clock) begin : check_response
      stream_byte_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (owed_bytes.size() == 0) begin
            error_count++;
            $error("unexpected byte %02h (last_of_run %0b)", rsp_out_byte, rsp_last_of_run);
         end else begin
            want = owed_bytes.pop_front();
            bytes_checked++;
            if (rsp_last_of_run) last_marks_seen++;
            if (rsp_out_byte !== want.value) begin
               error_count++;
               $error("out_byte: expected %02h, got %02h", want.value, rsp_out_byte);
            end
            if (rsp_last_of_run !== want.last) begin
               error_count++;
               $error("last_of_run: expected %0b, got %0b", want.last, rsp_last_of_run);
            end
         end
      end
   end

   // Hang detector: end the run after too long without any transfer.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= QuietLimit) begin
            $display("timeout: no transfer for %0d cycles", QuietLimit);
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   // Bit fields: single bit, empty field, full width, oversize count,
   // upper data bits that must be dropped, and unaligned packing across bytes.
   task automatic test_bit_fields();
      send_request(REQ_BITS, 64'h1, 6'd1, 1'b0, 1'b0);
      send_request(REQ_BITS, '1, 6'd0, 1'b1, 1'b1);
      send_request(REQ_BITS, 64'hDEAD_BEEF_1234_5678, 6'd32, 1'b1, 1'b0);
      send_request(REQ_BITS, '1, 6'd63, 1'b0, 1'b1);
      send_request(REQ_BITS, 64'h0, 6'd32, 1'b1, 1'b1);
      send_request(REQ_BITS, 64'hFFFF_FFFF_FFFF_FE5A, 6'd8, 1'b0, 1'b0);
      send_request(REQ_BITS, 64'h5, 6'd3, 1'b0, 1'b0);
      send_request(REQ_BITS, 64'h3C, 6'd7, 1'b1, 1'b1);
   endtask

   // Byte writes: nine bytes out of one request (partial padded first),
   // both byte orders, zero count with and without partial bits, oversize count.
   task automatic test_byte_writes();
      send_request(REQ_BYTES, 64'h0102_0304_0506_0708, 6'd8, 1'b1, 1'b0);
      send_request(REQ_BYTES, 64'hF1E2_D3C4_B5A6_9788, 6'd63, 1'b0, 1'b1);
      send_request(REQ_BITS, 64'h15, 6'd5, 1'b0, 1'b0);
      send_request(REQ_BYTES, '1, 6'd0, 1'b1, 1'b1);
      send_request(REQ_BYTES, '1, 6'd0, 1'b0, 1'b0);
      send_request(REQ_BYTES, 64'hAB, 6'd1, 1'b1, 1'b0);
      send_request(REQ_BYTES, 64'h1122_3344_5566_7788, 6'd3, 1'b0, 1'b1);
   endtask

   // Flushes: keep the partial byte, pad it out, flush when empty;
   // the unused code must leave the partial byte alone.
   task automatic test_flush_and_unused();
      send_request(REQ_BITS, 64'h9, 6'd4, 1'b0, 1'b0);
      send_request(REQ_FLUSH, '1, 6'd63, 1'b1, 1'b0);
      send_request(REQ_UNUSED, '1, 6'd8, 1'b1, 1'b1);
      send_request(REQ_FLUSH, random_data(), 6'd0, 1'b0, 1'b1);
      send_request(REQ_FLUSH, random_data(), 6'd5, 1'b1, 1'b1);
   endtask

   // Random mix weighted toward bit fields; ignored requests don't count.
   task automatic test_random_stream(input int items);
      int done;
      int pick;
      logic [FieldCntW-1:0] count;
      logic [1:0] kind;
      done = 0;
      while (done < items) begin
         pick = $urandom_range(0, 99);
         if (pick < 55) begin
            kind  = REQ_BITS;
            count = ($urandom_range(0, 9) == 0) ? FieldCntW'($urandom_range(0, 63))
                                               : FieldCntW'($urandom_range(1, MaxFieldBits));
         end else if (pick < 80) begin
            kind  = REQ_BYTES;
            count = ($urandom_range(0, 6) == 0) ? FieldCntW'($urandom_range(0, 63))
                                               : FieldCntW'($urandom_range(0, MaxWriteBytes));
         end else if (pick < 95) begin
            kind  = REQ_FLUSH;
            count = FieldCntW'($urandom_range(0, 63));
         end else begin
            kind  = REQ_UNUSED;
            count = FieldCntW'($urandom_range(0, 63));
         end
         send_request(kind, random_data(), count, 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)));
         if (kind != REQ_UNUSED) done++;
      end
   endtask

   initial begin
      model_partial   = '0;
      model_fill      = 0;
      idling_on       = 1'b0;
      rsp_stall_left  = 0;
      quiet_cycles    = 0;
      error_count     = 0;
      requests_sent   = 0;
      bytes_checked   = 0;
      last_marks_seen = 0;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_bit_fields();
      idling_on = 1'b1;
      test_byte_writes();
      test_flush_and_unused();
      test_random_stream(160);
      // Final stretch at full rate on both sides
      idling_on = 1'b0;
      test_random_stream(50);
      req_valid <= 1'b0;

      while (owed_bytes.size() != 0) @(posedge clock);
      repeat (TailCycles) @(posedge clock);

      $display("covered: %0d requests (bit fields, byte writes, flushes, unused code)",
               requests_sent);
      $display("checked: %0d bytes, %0d run ends, with and without idling on both sides",
               bytes_checked, last_marks_seen);
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

[sim.f]
src/msbw_pkg.sv
src/msbw_front.sv
src/msbw_queue.sv
src/msbw_back.sv
src/msb_first_bit_stream_writer_core.sv
tb/sv/testbench.sv
